FILE: rtl/core/fsp2_pkg.sv
package fsp2_pkg;

  localparam int unsigned ExpW  = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned CntW  = 9;
  localparam int unsigned ShW   = 6;

  localparam logic [ExpW-1:0] ExpMax    = 8'hFF;
  localparam logic [ExpW-1:0] ExpMaxFin = 8'd254;
  localparam logic [CntW-1:0] SatCount  = 9'd277;

  typedef struct packed {
    logic              sign;
    logic              pass;
    logic              down;
    logic [ExpW-1:0]   exp;
    logic [FracW-1:0]  frac;
    logic [CntW-1:0]   count;
    logic [31:0]       orig;
  } dec_t;

  typedef struct packed {
    logic              sign;
    logic              pass;
    logic              down;
    logic [FracW:0]    sig;
    logic signed [10:0] enew;
    logic [31:0]       orig;
  } norm_t;

  function automatic logic [4:0] lzc23(input logic [FracW-1:0] m);
    logic [4:0] n;
    logic       found;
    n = 5'd0;
    found = 1'b0;
    for (int i = FracW - 1; i >= 0; i--) begin
      if (!found && m[i]) begin
        found = 1'b1;
        n = 5'(FracW - 1 - i);
      end
    end
    return n;
  endfunction

endpackage

FILE: rtl/core/fsp2_decode.sv
module fsp2_decode (
  input  logic          [31:0]        value_bits_i,
  input  logic                        direction_i,
  input  logic [fsp2_pkg::CntW-1:0]   shift_count_i,
  output fsp2_pkg::dec_t              dec_o
);

  logic [fsp2_pkg::ExpW-1:0]  e;
  logic [fsp2_pkg::FracW-1:0] m;
  logic [fsp2_pkg::CntW-1:0]  c;

  always_comb begin
    e = value_bits_i[30:23];
    m = value_bits_i[22:0];
    c = (shift_count_i > fsp2_pkg::SatCount) ? fsp2_pkg::SatCount : shift_count_i;
    dec_o.sign  = value_bits_i[31];
    dec_o.down  = direction_i;
    dec_o.exp   = e;
    dec_o.frac  = m;
    dec_o.count = c;
    dec_o.orig  = value_bits_i;
    dec_o.pass  = (c == '0) || (e == fsp2_pkg::ExpMax) || ((e == '0) && (m == '0));
  end

endmodule

FILE: rtl/core/fsp2_norm.sv
module fsp2_norm (
  input  fsp2_pkg::dec_t  dec_i,
  output fsp2_pkg::norm_t norm_o
);

  logic [4:0]         lz;
  logic signed [10:0] eff;
  logic [fsp2_pkg::FracW:0] sig;

  always_comb begin
    lz  = fsp2_pkg::lzc23(dec_i.frac);
    if (dec_i.exp == '0) begin
      sig = {1'b0, dec_i.frac} << (lz + 5'd1);
      eff = -11'sd0 - 11'(lz);
    end else begin
      sig = {1'b1, dec_i.frac};
      eff = 11'(dec_i.exp);
    end
    norm_o.sign = dec_i.sign;
    norm_o.pass = dec_i.pass;
    norm_o.down = dec_i.down;
    norm_o.orig = dec_i.orig;
    norm_o.sig  = sig;
    norm_o.enew = dec_i.down ? eff - 11'(dec_i.count) : eff + 11'(dec_i.count);
  end

endmodule

FILE: rtl/core/fsp2_pack.sv
module fsp2_pack (
  input  fsp2_pkg::norm_t norm_i,
  output logic [31:0]     result_o
);

  logic [fsp2_pkg::FracW:0] sh;
  logic [8:0]               amt;

  always_comb begin
    amt = 9'(11'sd1 - norm_i.enew);
    sh  = (amt > 9'd24) ? '0 : (norm_i.sig >> amt);
    if (norm_i.pass) begin
      result_o = norm_i.orig;
    end else if (norm_i.enew > 11'sd254) begin
      result_o = {norm_i.sign, fsp2_pkg::ExpMax, 23'd0};
    end else if (norm_i.enew >= 11'sd1) begin
      result_o = {norm_i.sign, norm_i.enew[7:0], norm_i.sig[22:0]};
    end else begin
      result_o = {norm_i.sign, 8'd0, sh[22:0]};
    end
  end

endmodule

FILE: rtl/core/float32_scale_by_power_of_two_core.sv
// Scale a single-precision bit pattern by a power of two.
// Input stream: s_axis, tdata = value_bits[31:0], direction[32], shift_count[41:33].
// Output stream: m_axis, tdata = result_bits.
// Three register stages: decode, normalize plus exponent add, pack.
// An accepted input beat passes the decode, normalize and pack registers in
// order, and m_axis_tvalid rises once the beat is held in the pack register.
// Throughput is one beat per cycle while no stall on m_axis_tready backs up the pipe.
// Each stage advances when its successor is empty or advancing, so a
// stall on m_axis_tready backs up through the pipe without loss and
// s_axis_tready drops only when all stages are full and m_axis_tready is low.
// Reset clears all valid bits; data registers are not reset.
// Large counts saturate at 277; NaN, infinity, zero and count zero pass.
// Underflow truncates toward zero rather than rounding.
module float32_scale_by_power_of_two_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // value_bits[31:0], direction[32], shift_count[41:33]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // result_bits[31:0]
);

  fsp2_pkg::dec_t  dec_d, dec_q;
  fsp2_pkg::norm_t norm_d, norm_q;
  logic [31:0]     res_d, res_q;
  logic            v1_q, v2_q, v3_q;
  logic            en1, en2, en3;

  assign en3 = !v3_q || m_axis_tready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;
  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = res_q;

  fsp2_decode u_dec (
    .value_bits_i  (s_axis_tdata[31:0]),
    .direction_i   (s_axis_tdata[32]),
    .shift_count_i (s_axis_tdata[41:33]),
    .dec_o         (dec_d)
  );

  fsp2_norm u_norm (.dec_i(dec_q), .norm_o(norm_d));
  fsp2_pack u_pack (.norm_i(norm_q), .result_o(res_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) dec_q  <= dec_d;
    if (en2) norm_q <= norm_d;
    if (en3) res_q  <= res_d;
  end

endmodule

FILE: rtl/core/fsp2_checker.sv
module fsp2_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped or changed under stall");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
    |=> m_axis_tvalid)
    else $error("beat did not appear after three cycles");

endmodule

bind float32_scale_by_power_of_two_core fsp2_checker u_fsp2_checker (.*);
